// ===== sv/dlr_pkg.sv =====
// Shared widths and constants for the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

  // Coordinate tile and fixed-point format
  localparam int unsigned CoordRange = 64;
  localparam int unsigned CoordW     = $clog2(CoordRange);
  localparam int unsigned FracBits   = 16;
  // Slope quotient and accumulator: whole part plus fraction
  localparam int unsigned QuotW      = CoordW + FracBits;
  localparam int unsigned QuotCntW   = $clog2(QuotW);

  // Frame buffer
  localparam int unsigned PitchW     = 13;
  localparam int unsigned AddrW      = 18;
  localparam int unsigned ColorW     = 32;
  localparam int unsigned MulCntW    = $clog2(CoordW);

  localparam logic [PitchW-1:0]   PitchReset = PitchW'(64);
  localparam logic [FracBits-1:0] FracHalf   = FracBits'(1) << (FracBits - 1);

endpackage

`default_nettype wire

// ===== sv/dlr_divider.sv =====
// Bit-serial restoring divider for the slope: (magnitude << FracBits) / span.
`timescale 1ns / 1ps
`default_nettype none

module dlr_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    magnitude_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    divisor_i,
  output logic                               busy_o,
  output logic [dlr_pkg::QuotW-1:0]          quotient_o
);

  logic                           run_q, run_d;
  logic [dlr_pkg::QuotCntW-1:0]   cnt_q, cnt_d;
  logic [dlr_pkg::QuotW-1:0]      dvd_q, dvd_d;
  logic [dlr_pkg::QuotW-1:0]      quot_q, quot_d;
  logic [dlr_pkg::CoordW-1:0]     rem_q, rem_d;
  logic [dlr_pkg::CoordW-1:0]     div_q, div_d;
  logic [dlr_pkg::CoordW:0]       shifted;
  logic [dlr_pkg::CoordW+1:0]     trial;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, dvd_q[dlr_pkg::QuotW-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    run_d   = run_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = dlr_pkg::QuotCntW'(dlr_pkg::QuotW - 1);
      dvd_d  = {magnitude_i, {dlr_pkg::FracBits{1'b0}}};
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (run_q) begin
      dvd_d = {dvd_q[dlr_pkg::QuotW-2:0], 1'b0};
      if (trial[dlr_pkg::CoordW+1]) begin
        rem_d  = shifted[dlr_pkg::CoordW-1:0];
        quot_d = {quot_q[dlr_pkg::QuotW-2:0], 1'b0};
      end else begin
        rem_d  = trial[dlr_pkg::CoordW-1:0];
        quot_d = {quot_q[dlr_pkg::QuotW-2:0], 1'b1};
      end
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o     = run_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

// ===== sv/dlr_row_mult.sv =====
// Bit-serial shift-add multiplier for the first row offset y * pitch.
`timescale 1ns / 1ps
`default_nettype none

module dlr_row_mult (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    row_i,
  input  wire logic [dlr_pkg::PitchW-1:0]    pitch_i,
  output logic                               busy_o,
  output logic [dlr_pkg::AddrW-1:0]          product_o
);

  logic                           run_q, run_d;
  logic [dlr_pkg::MulCntW-1:0]    cnt_q, cnt_d;
  logic [dlr_pkg::CoordW-1:0]     row_q, row_d;
  logic [dlr_pkg::AddrW-1:0]      prod_q, prod_d;
  logic [dlr_pkg::AddrW-1:0]      addend;

  // Take one multiplier bit per cycle, most significant first
  always_comb begin
    addend = row_q[dlr_pkg::CoordW-1] ? dlr_pkg::AddrW'(pitch_i) : '0;
    run_d  = run_q;
    cnt_d  = cnt_q;
    row_d  = row_q;
    prod_d = prod_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = dlr_pkg::MulCntW'(dlr_pkg::CoordW - 1);
      row_d  = row_i;
      prod_d = '0;
    end else if (run_q) begin
      prod_d = {prod_q[dlr_pkg::AddrW-2:0], 1'b0} + addend;
      row_d  = {row_q[dlr_pkg::CoordW-2:0], 1'b0};
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    prod_q <= prod_d;
  end

  assign busy_o    = run_q;
  assign product_o = prod_q;

endmodule

`default_nettype wire

// ===== sv/dda_line_rasterizer_unit.sv =====
// Top level of the DDA line rasterizer: setup, stepping and pixel output.
`timescale 1ns / 1ps
`default_nettype none

// A line is taken when start is high and busy is low. The slope is found by a
// bit-serial divider, one quotient bit per cycle over 22 bits, while a
// bit-serial multiplier forms the first row offset; the line then emits one
// pixel write per cycle along its major axis. Each pixel is shown for exactly
// one cycle with pixel_valid_o high, and the receiver cannot stall it.
// last_pixel_o marks the final pixel. The row pitch is written through the
// cfg port, which is always ready; write it only while busy is low.
module dda_line_rasterizer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Line command
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dlr_pkg::CoordW-1:0]    start_x_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    start_y_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    end_x_i,
  input  wire logic [dlr_pkg::CoordW-1:0]    end_y_i,
  input  wire logic [dlr_pkg::ColorW-1:0]    line_color_i,
  // Pixel writes
  output logic                               pixel_valid_o,
  output logic [dlr_pkg::CoordW-1:0]         pixel_x_o,
  output logic [dlr_pkg::CoordW-1:0]         pixel_y_o,
  output logic [dlr_pkg::AddrW-1:0]          word_address_o,
  output logic [dlr_pkg::ColorW-1:0]         pixel_color_o,
  output logic                               last_pixel_o,
  // Row pitch register
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dlr_pkg::PitchW-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StStep
  } state_e;

  localparam int unsigned CW = dlr_pkg::CoordW;
  localparam int unsigned QW = dlr_pkg::QuotW;
  localparam int unsigned AW = dlr_pkg::AddrW;

  state_e                 state_q, state_d;
  logic [dlr_pkg::PitchW-1:0] pitch_q;

  // Per-line registers
  logic                   mode_y_q, mode_y_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          major_q, major_d;
  logic [CW-1:0]          minor_q, minor_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [QW-1:0]          accb_q, accb_d;
  logic [AW-1:0]          row_q, row_d;
  logic [dlr_pkg::ColorW-1:0] color_q, color_d;

  // Output registers
  logic                   ovalid_q, ovalid_d;
  logic [CW-1:0]          ox_q, ox_d;
  logic [CW-1:0]          oy_q, oy_d;
  logic [AW-1:0]          oaddr_q, oaddr_d;
  logic                   olast_q, olast_d;

  // Setup decode
  logic                   accept;
  logic [CW:0]            dx, dy, dmin;
  logic [CW-1:0]          adx, ady;
  logic                   in_mode_y, in_swap;
  logic [CW-1:0]          xa, ya, xb, yb;
  logic [CW-1:0]          maj0, maj1, min0, min1, mag;

  // Serial units
  logic                   div_busy, mul_busy;
  logic [QW-1:0]          quotient;
  logic [AW-1:0]          product;

  // Stepping
  logic [QW-1:0]          accb_base;
  logic [CW-1:0]          next_minor;
  logic [CW-1:0]          cur_x, cur_y;
  logic [AW-1:0]          pitch_ext;

  assign accept      = start && (state_q == StIdle);
  assign cfg_ready_o = 1'b1;

  // Pick the major axis and order the endpoints so stepping goes upward
  always_comb begin
    dx        = {1'b0, end_x_i} - {1'b0, start_x_i};
    dy        = {1'b0, end_y_i} - {1'b0, start_y_i};
    adx       = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady       = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    in_mode_y = (start_x_i == end_x_i) || (ady > adx);
    in_swap   = in_mode_y ? (start_y_i > end_y_i) : (start_x_i > end_x_i);
    xa        = in_swap ? end_x_i : start_x_i;
    ya        = in_swap ? end_y_i : start_y_i;
    xb        = in_swap ? start_x_i : end_x_i;
    yb        = in_swap ? start_y_i : end_y_i;
    maj0      = in_mode_y ? ya : xa;
    maj1      = in_mode_y ? yb : xb;
    min0      = in_mode_y ? xa : ya;
    min1      = in_mode_y ? xb : yb;
    dmin      = {1'b0, min1} - {1'b0, min0};
    mag       = dmin[CW] ? CW'(-dmin) : dmin[CW-1:0];
  end

  dlr_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .magnitude_i (mag),
    .divisor_i   (maj1 - maj0),
    .busy_o      (div_busy),
    .quotient_o  (quotient)
  );

  dlr_row_mult u_row_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .row_i     (ya),
    .pitch_i   (pitch_q),
    .busy_o    (mul_busy),
    .product_o (product)
  );

  // Sequence setup and stepping
  always_comb begin
    accb_base  = {minor_q, dlr_pkg::FracHalf};
    next_minor = accb_q[QW-1 -: CW];
    cur_x      = mode_y_q ? minor_q : major_q;
    cur_y      = mode_y_q ? major_q : minor_q;
    pitch_ext  = AW'(pitch_q);

    state_d  = state_q;
    mode_y_d = mode_y_q;
    neg_d    = neg_q;
    major_d  = major_q;
    minor_d  = minor_q;
    cnt_d    = cnt_q;
    accb_d   = accb_q;
    row_d    = row_q;
    color_d  = color_q;
    ovalid_d = 1'b0;
    ox_d     = ox_q;
    oy_d     = oy_q;
    oaddr_d  = oaddr_q;
    olast_d  = olast_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d  = StCalc;
          mode_y_d = in_mode_y;
          neg_d    = dmin[CW];
          major_d  = maj0;
          minor_d  = min0;
          cnt_d    = maj1 - maj0;
          color_d  = line_color_i;
        end
      end
      StCalc: begin
        // Load the biased accumulator one step ahead of the current pixel
        if (!div_busy && !mul_busy) begin
          state_d = StStep;
          accb_d  = neg_q ? (accb_base - quotient) : (accb_base + quotient);
          row_d   = product;
        end
      end
      StStep: begin
        // Emit the current pixel and advance one step
        ovalid_d = 1'b1;
        ox_d     = cur_x;
        oy_d     = cur_y;
        oaddr_d  = AW'(cur_x) + row_q;
        olast_d  = (cnt_q == '0);
        major_d  = major_q + 1'b1;
        minor_d  = next_minor;
        accb_d   = neg_q ? (accb_q - quotient) : (accb_q + quotient);
        cnt_d    = cnt_q - 1'b1;
        if (mode_y_q || (next_minor > minor_q)) begin
          row_d = row_q + pitch_ext;
        end else if (next_minor < minor_q) begin
          row_d = row_q - pitch_ext;
        end
        if (cnt_q == '0) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, output strobe and the pitch register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      pitch_q  <= dlr_pkg::PitchReset;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pitch_q <= cfg_data_i;
      end
    end
  end

  // Line and pixel payload
  always_ff @(posedge clk_i) begin
    mode_y_q <= mode_y_d;
    neg_q    <= neg_d;
    major_q  <= major_d;
    minor_q  <= minor_d;
    cnt_q    <= cnt_d;
    accb_q   <= accb_d;
    row_q    <= row_d;
    color_q  <= color_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oaddr_q  <= oaddr_d;
    olast_q  <= olast_d;
  end

  assign busy           = (state_q != StIdle);
  assign pixel_valid_o  = ovalid_q;
  assign pixel_x_o      = ox_q;
  assign pixel_y_o      = oy_q;
  assign word_address_o = oaddr_q;
  assign pixel_color_o  = color_q;
  assign last_pixel_o   = olast_q;

endmodule

`default_nettype wire
